/* hw/rtl/six_actuator_homing_stepper_defines.svh */
// Assertion macros for the six-actuator homing stepper.
// Used by the port checker; needs signals named clock and reset in scope.
`ifndef SIX_ACTUATOR_HOMING_STEPPER_DEFINES_SVH
`define SIX_ACTUATOR_HOMING_STEPPER_DEFINES_SVH

// Checked at every edge outside reset
`define SAHS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define SAHS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/sahs_pkg.sv */
// Shared types, constants and helpers of the six-actuator homing stepper.
// No dependencies; imported by the channel interfaces, the lane, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sahs_pkg;

   localparam int NUM_ACT    = 6;
   localparam int POS_W      = 16;
   localparam int CALC_W     = 19;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [CALC_W-1:0] calc_type;

   // Register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_TARGET_MODE     = 4'd0,
      REG_FAST_STEP       = 4'd1,
      REG_SLOW_STEP       = 4'd2,
      REG_BAND_MARGIN     = 4'd3,
      REG_REACH_TOLERANCE = 4'd4,
      REG_MIDDLE_POINT    = 4'd5,
      REG_TOP_POINT       = 4'd6,
      REG_COMMAND_CEILING = 4'd7
   } csr_reg_type;

   // Target modes
   localparam logic MODE_SEEK_MIDDLE = 1'b0;
   localparam logic MODE_LEAD_ZERO   = 1'b1;

   typedef struct packed {
      logic        target_mode;
      logic [9:0]  fast_step;
      logic [9:0]  slow_step;
      logic [12:0] band_margin;
      logic [9:0]  reach_tolerance;
      logic [13:0] middle_point;
      logic [13:0] top_point;
      logic [13:0] command_ceiling;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      target_mode:     MODE_SEEK_MIDDLE,
      fast_step:       10'd100,
      slow_step:       10'd50,
      band_margin:     13'd1000,
      reach_tolerance: 10'd35,
      middle_point:    14'd5000,
      top_point:       14'd10000,
      command_ceiling: 14'd9500
   };

   // Per-lane result handed to the top level
   typedef struct packed {
      logic    low_ok;
      logic    mid_ok;
      logic    top_ok;
      pos_type cmd;
   } lane_out_type;

   localparam calc_type POS_MAX = calc_type'(32767);
   localparam calc_type POS_MIN = -calc_type'(32768);

   function automatic calc_type abs_calc(input calc_type v);
      abs_calc = (v < 0) ? -v : v;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sahs_channels.sv */
// Valid/ready channel interfaces: request, response and register write.
// Depends on sahs_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface sahs_req_if;
   import sahs_pkg::*;
   logic    valid;
   logic    ready;
   pos_type pos_0;
   pos_type pos_1;
   pos_type pos_2;
   pos_type pos_3;
   pos_type pos_4;
   pos_type pos_5;
   modport source (output valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, input ready);
   modport sink   (input valid, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5, output ready);
endinterface

interface sahs_rsp_if;
   import sahs_pkg::*;
   logic    valid;
   logic    ready;
   pos_type cmd_0;
   pos_type cmd_1;
   pos_type cmd_2;
   pos_type cmd_3;
   pos_type cmd_4;
   pos_type cmd_5;
   logic    at_lowest;
   logic    at_middle;
   logic    at_topmost;
   logic    target_done;
   modport source (output valid, cmd_0, cmd_1, cmd_2, cmd_3, cmd_4, cmd_5,
                   at_lowest, at_middle, at_topmost, target_done, input ready);
   modport sink   (input valid, cmd_0, cmd_1, cmd_2, cmd_3, cmd_4, cmd_5,
                   at_lowest, at_middle, at_topmost, target_done, output ready);
endinterface

interface sahs_csr_if;
   import sahs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sahs_lane.sv */
// One actuator lane: reach checks and next command for both target modes.
// Depends on sahs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sahs_lane (
   input  sahs_pkg::pos_type      pos,
   input  sahs_pkg::cfg_type      cfg,
   output sahs_pkg::lane_out_type result
);
   import sahs_pkg::*;

   calc_type p, mid, top, mar, tol, fast, slow, ceil;
   calc_type seek_r, lead_r;
   pos_type  seek_cmd, lead_cmd;

   // Widen everything to one signed width
   always_comb begin
      p    = calc_type'(pos);
      mid  = CALC_W'(cfg.middle_point);
      top  = CALC_W'(cfg.top_point);
      mar  = CALC_W'(cfg.band_margin);
      tol  = CALC_W'(cfg.reach_tolerance);
      fast = CALC_W'(cfg.fast_step);
      slow = CALC_W'(cfg.slow_step);
      ceil = CALC_W'(cfg.command_ceiling);
   end

   // Seek middle: fast inside the band, slow near the ends, then clamp
   always_comb begin
      if (p < mid) begin
         seek_r = (p > mar && p < mid - mar) ? p + fast : p + slow;
      end else if (p > mid) begin
         seek_r = (p > mid + mar && p < top - mar) ? p - fast : p - slow;
      end else begin
         seek_r = mid;
      end
      if (seek_r >= ceil) seek_r = ceil;
      if (seek_r <= 0) seek_r = '0;
      seek_cmd = seek_r[POS_W-1:0];
   end

   // Lead to zero: always slow, saturate to 16 bits
   always_comb begin
      if (p < tol) begin
         lead_r = p + slow;
      end else if (p > tol) begin
         lead_r = p - slow;
      end else begin
         lead_r = '0;
      end
      if (lead_r > POS_MAX) begin
         lead_cmd = pos_type'(POS_MAX[POS_W-1:0]);
      end else if (lead_r < POS_MIN) begin
         lead_cmd = pos_type'(POS_MIN[POS_W-1:0]);
      end else begin
         lead_cmd = lead_r[POS_W-1:0];
      end
   end

   // Reach checks; top allows twice the tolerance
   always_comb begin
      result.low_ok = abs_calc(p) <= tol;
      result.mid_ok = abs_calc(p - mid) <= tol;
      result.top_ok = abs_calc(p - top) <= (tol <<< 1);
      result.cmd    = (cfg.target_mode == MODE_LEAD_ZERO) ? lead_cmd : seek_cmd;
   end

endmodule

`default_nettype wire

/* hw/rtl/six_actuator_homing_stepper.sv */
// Top level of the six-actuator homing stepper.
// Depends on sahs_pkg, the channel interfaces and sahs_lane.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request of six measured positions per clock while the response
// side is not stalled and returns one response per request, in order, from
// the response register. The request is captured in an input
// register; six parallel lanes of compares and adders then produce the
// reach flags and the next commands, which land in the response register.
// While the selected target is not reached the new commands are stored;
// once it is reached the stored commands are repeated. Throughput is one
// request per cycle; up to two requests are held when the response side
// stalls. Register writes are always accepted and take effect at once;
// change them only while no request is in flight.

module six_actuator_homing_stepper (
   input wire logic  clock,
   input wire logic  reset,
   sahs_req_if.sink  req_ch,
   sahs_rsp_if.source rsp_ch,
   sahs_csr_if.sink  csr_ch
);
   import sahs_pkg::*;

   cfg_type      cfg_ff;
   logic         s1_valid_ff;
   pos_type      s1_pos_ff [NUM_ACT];
   pos_type      req_pos [NUM_ACT];
   pos_type      held_ff [NUM_ACT];
   pos_type      cmd_in [NUM_ACT];
   pos_type      rsp_cmd_ff [NUM_ACT];
   lane_out_type lane_out [NUM_ACT];
   logic         rsp_valid_ff;
   logic         rsp_low_ff, rsp_mid_ff, rsp_top_ff, rsp_done_ff;
   logic         low_all, mid_all, top_all, done_in;
   logic         advance;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            REG_TARGET_MODE:     cfg_ff.target_mode     <= csr_ch.data[0];
            REG_FAST_STEP:       cfg_ff.fast_step       <= csr_ch.data[9:0];
            REG_SLOW_STEP:       cfg_ff.slow_step       <= csr_ch.data[9:0];
            REG_BAND_MARGIN:     cfg_ff.band_margin     <= csr_ch.data[12:0];
            REG_REACH_TOLERANCE: cfg_ff.reach_tolerance <= csr_ch.data[9:0];
            REG_MIDDLE_POINT:    cfg_ff.middle_point    <= csr_ch.data[13:0];
            REG_TOP_POINT:       cfg_ff.top_point       <= csr_ch.data[13:0];
            REG_COMMAND_CEILING: cfg_ff.command_ceiling <= csr_ch.data[13:0];
            default: ;
         endcase
      end
   end

   // Flow control: stage 1 moves on when the response register frees up
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;

   assign req_pos[0] = req_ch.pos_0;
   assign req_pos[1] = req_ch.pos_1;
   assign req_pos[2] = req_ch.pos_2;
   assign req_pos[3] = req_ch.pos_3;
   assign req_pos[4] = req_ch.pos_4;
   assign req_pos[5] = req_ch.pos_5;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_pos_ff <= req_pos;
      end
   end

   // Lanes
   for (genvar i = 0; i < NUM_ACT; i++) begin : g_lane
      sahs_lane u_lane (
         .pos    (s1_pos_ff[i]),
         .cfg    (cfg_ff),
         .result (lane_out[i])
      );
   end

   // Combine flags and pick new or held commands
   always_comb begin
      low_all = 1'b1;
      mid_all = 1'b1;
      top_all = 1'b1;
      for (int i = 0; i < NUM_ACT; i++) begin
         low_all = low_all & lane_out[i].low_ok;
         mid_all = mid_all & lane_out[i].mid_ok;
         top_all = top_all & lane_out[i].top_ok;
      end
      done_in = (cfg_ff.target_mode == MODE_LEAD_ZERO) ? low_all : mid_all;
      for (int i = 0; i < NUM_ACT; i++) begin
         cmd_in[i] = done_in ? held_ff[i] : lane_out[i].cmd;
      end
   end

   // Held commands
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ACT; i++) held_ff[i] <= '0;
      end else if (s1_valid_ff && advance && !done_in) begin
         held_ff <= cmd_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         rsp_cmd_ff  <= cmd_in;
         rsp_low_ff  <= low_all;
         rsp_mid_ff  <= mid_all;
         rsp_top_ff  <= top_all;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.cmd_0       = rsp_cmd_ff[0];
   assign rsp_ch.cmd_1       = rsp_cmd_ff[1];
   assign rsp_ch.cmd_2       = rsp_cmd_ff[2];
   assign rsp_ch.cmd_3       = rsp_cmd_ff[3];
   assign rsp_ch.cmd_4       = rsp_cmd_ff[4];
   assign rsp_ch.cmd_5       = rsp_cmd_ff[5];
   assign rsp_ch.at_lowest   = rsp_low_ff;
   assign rsp_ch.at_middle   = rsp_mid_ff;
   assign rsp_ch.at_topmost  = rsp_top_ff;
   assign rsp_ch.target_done = rsp_done_ff;

endmodule

`default_nettype wire

/* hw/rtl/sahs_checker.sv */
// Port-level checks of the six-actuator homing stepper, bound to the top.
// Depends on six_actuator_homing_stepper_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "six_actuator_homing_stepper_defines.svh"

module sahs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic at_lowest,
   input wire logic at_middle,
   input wire logic target_done
);

   // A response waiting to be taken stays offered
   `SAHS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // Done only ever follows from one of the two reach flags
   `SAHS_ASSERT(a_done_flag, rsp_valid && target_done |-> at_lowest || at_middle, "done without reach flag")

   // Requests are refused only while a response is stalled
   `SAHS_ASSERT(a_ready_stall, !req_ready |-> rsp_valid && !rsp_ready, "request refused without backpressure")

   // Nothing is offered right after reset
   `SAHS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind six_actuator_homing_stepper sahs_checker u_sahs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .at_lowest   (rsp_ch.at_lowest),
   .at_middle   (rsp_ch.at_middle),
   .target_done (rsp_ch.target_done)
);

`default_nettype wire

/* verif/six_actuator_homing_stepper_test.sv */
// Self-checking testbench for the six-actuator homing stepper: directed and
// random position requests across many register settings, checked in order.
// Depends on sahs_pkg, the channel interfaces and the stepper RTL.
`timescale 1ns / 1ps

module six_actuator_homing_stepper_test;
   import sahs_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 21;
   localparam int PHASE_ITEMS  = 116;
   localparam int RANDOM_PHASES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_CYCLES = 6;

   typedef logic [NUM_ACT-1:0][POS_W-1:0] pos_set_type;

   typedef struct packed {
      logic [NUM_ACT-1:0][POS_W-1:0] cmd;
      logic at_lowest;
      logic at_middle;
      logic at_topmost;
      logic target_done;
   } homing_result_type;

   logic clock = 1'b0;
   logic reset;

   sahs_req_if req_if ();
   sahs_rsp_if rsp_if ();
   sahs_csr_if csr_if ();

   six_actuator_homing_stepper dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predictor state: register copy and held commands
   cfg_type     live_cfg;
   pos_set_type held_cmd;

   pos_set_type       position_backlog [$];
   homing_result_type expected_commands [$];
   pos_set_type       next_item;

   logic req_taken;
   logic steady_run;
   logic hold_off_armed;
   logic hold_off_done;
   int   hold_left;
   int   items_queued;
   int   request_count;
   int   response_count;
   int   done_count;
   int   fault_count;
   int   settings_count;
   int   cycle_count;

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Arithmetic helpers
   // ---------------------------------------------------------------
   function automatic logic [POS_W-1:0] clip16(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return POS_W'(v);
   endfunction

   function automatic int mag(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int pick_value(input int top_value, input int lo, input int hi);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return top_value;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // Next commands and reach flags for one tick; updates the held commands
   function automatic homing_result_type homing_step(input pos_set_type pos);
      homing_result_type res;
      int p, r, tol, mid, top, mar, slow, fast, ceil_v;
      tol    = int'(live_cfg.reach_tolerance);
      mid    = int'(live_cfg.middle_point);
      top    = int'(live_cfg.top_point);
      mar    = int'(live_cfg.band_margin);
      slow   = int'(live_cfg.slow_step);
      fast   = int'(live_cfg.fast_step);
      ceil_v = int'(live_cfg.command_ceiling);
      res.at_lowest  = 1'b1;
      res.at_middle  = 1'b1;
      res.at_topmost = 1'b1;
      for (int a = 0; a < NUM_ACT; a++) begin
         p = int'($signed(pos[a]));
         if (mag(p) > tol) res.at_lowest = 1'b0;
         if (mag(p - mid) > tol) res.at_middle = 1'b0;
         if (mag(p - top) > 2 * tol) res.at_topmost = 1'b0;
      end
      res.target_done = (live_cfg.target_mode == MODE_LEAD_ZERO) ? res.at_lowest
                                                                : res.at_middle;
      if (!res.target_done) begin
         for (int a = 0; a < NUM_ACT; a++) begin
            p = int'($signed(pos[a]));
            if (live_cfg.target_mode == MODE_LEAD_ZERO) begin
               // slow step toward zero, exact tolerance snaps to zero
               if (p < tol) r = p + slow;
               else if (p > tol) r = p - slow;
               else r = 0;
            end else begin
               // fast inside the central band, slow near the stroke ends
               if (p < mid) begin
                  r = (p > mar && p < mid - mar) ? p + fast : p + slow;
               end else if (p > mid) begin
                  r = (p > mid + mar && p < top - mar) ? p - fast : p - slow;
               end else begin
                  r = mid;
               end
               if (r >= ceil_v) r = ceil_v;
               if (r <= 0) r = 0;
            end
            held_cmd[a] = clip16(r);
         end
      end
      res.cmd = held_cmd;
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         fault_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // Request driver: one request per handshake, random gaps
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (position_backlog.size() != 0 &&
             (steady_run || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_item = position_backlog.pop_front();
            req_if.valid <= 1'b1;
            req_if.pos_0 <= next_item[0];
            req_if.pos_1 <= next_item[1];
            req_if.pos_2 <= next_item[2];
            req_if.pos_3 <= next_item[3];
            req_if.pos_4 <= next_item[4];
            req_if.pos_5 <= next_item[5];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         hold_left     <= 0;
         hold_off_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_off_armed && !hold_off_done) begin
         hold_left     <= HOLD_CYCLES;
         hold_off_done <= 1'b1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------
   // Monitor: track register writes, predict accepted requests,
   // check responses against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      homing_result_type want;
      homing_result_type seen;
      if (reset) begin
         live_cfg  = CFG_RESET;
         held_cmd  = '0;
         expected_commands.delete();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.addr)
               REG_TARGET_MODE:     live_cfg.target_mode     = csr_if.data[0];
               REG_FAST_STEP:       live_cfg.fast_step       = csr_if.data[9:0];
               REG_SLOW_STEP:       live_cfg.slow_step       = csr_if.data[9:0];
               REG_BAND_MARGIN:     live_cfg.band_margin     = csr_if.data[12:0];
               REG_REACH_TOLERANCE: live_cfg.reach_tolerance = csr_if.data[9:0];
               REG_MIDDLE_POINT:    live_cfg.middle_point    = csr_if.data[13:0];
               REG_TOP_POINT:       live_cfg.top_point       = csr_if.data[13:0];
               REG_COMMAND_CEILING: live_cfg.command_ceiling = csr_if.data[13:0];
               default: ;  // unmapped index, ignored
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            expected_commands.push_back(homing_step({req_if.pos_5, req_if.pos_4,
               req_if.pos_3, req_if.pos_2, req_if.pos_1, req_if.pos_0}));
            request_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            response_count++;
            seen.cmd = {rsp_if.cmd_5, rsp_if.cmd_4, rsp_if.cmd_3,
                        rsp_if.cmd_2, rsp_if.cmd_1, rsp_if.cmd_0};
            seen.at_lowest   = rsp_if.at_lowest;
            seen.at_middle   = rsp_if.at_middle;
            seen.at_topmost  = rsp_if.at_topmost;
            seen.target_done = rsp_if.target_done;
            if (expected_commands.size() == 0) begin
               fault_count++;
               $display("%0t ns: response with no request outstanding, expected none, actual %h",
                        $time, seen);
            end else begin
               want = expected_commands.pop_front();
               if (want.target_done) done_count++;
               for (int a = 0; a < NUM_ACT; a++)
                  check_field($sformatf("cmd_%0d", a), $signed(want.cmd[a]),
                              $signed(seen.cmd[a]));
               check_field("at_lowest", want.at_lowest, seen.at_lowest);
               check_field("at_middle", want.at_middle, seen.at_middle);
               check_field("at_topmost", want.at_topmost, seen.at_topmost);
               check_field("target_done", want.target_done, seen.target_done);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("six_actuator_homing_stepper_test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_item(input pos_set_type item);
      position_backlog.push_back(item);
      items_queued++;
   endtask

   task automatic queue_lanes(input int a0, input int a1, input int a2,
                              input int a3, input int a4, input int a5);
      queue_item({clip16(a5), clip16(a4), clip16(a3), clip16(a2), clip16(a1), clip16(a0)});
   endtask

   // Register write while idle; bits above the field width are random
   task automatic set_register(input logic [CSR_ADDR_W-1:0] idx, input int value,
                               input int width);
      int mask;
      mask = (1 << width) - 1;
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= idx;
      csr_if.data  <= CSR_DATA_W'(($urandom & ~mask) | (value & mask));
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Hold the sender until every expected response has come back
   task automatic wait_drained();
      do @(posedge clock);
      while (position_backlog.size() != 0 || req_if.valid || expected_commands.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_random_settings(input logic mode);
      int mid;
      mid = pick_value(16383, 2000, 9000);
      set_register(REG_TARGET_MODE, mode, 1);
      set_register(REG_FAST_STEP, pick_value(1023, 20, 400), 10);
      set_register(REG_SLOW_STEP, pick_value(1023, 5, 150), 10);
      set_register(REG_BAND_MARGIN, pick_value(8191, 100, 3000), 13);
      set_register(REG_REACH_TOLERANCE, pick_value(1023, 5, 200), 10);
      set_register(REG_MIDDLE_POINT, mid, 14);
      set_register(REG_TOP_POINT, pick_value(16383, mid, 16383), 14);
      set_register(REG_COMMAND_CEILING, pick_value(16383, 6000, 16383), 14);
      set_register(REG_COMMAND_CEILING + 4'($urandom_range(1, 8)), $urandom, 16);
      settings_count++;
   endtask

   // Actuators converging on a target, then settling within or just outside the tolerance
   task automatic queue_homing_run();
      pos_set_type item;
      int goal, spread, steps, settle, jit;
      int start [NUM_ACT];
      case ($urandom_range(0, 9))
         0, 1: begin
            goal   = int'(live_cfg.top_point);
            spread = 2 * int'(live_cfg.reach_tolerance);
         end
         2, 3: begin
            goal   = (live_cfg.target_mode == MODE_LEAD_ZERO) ? int'(live_cfg.middle_point) : 0;
            spread = int'(live_cfg.reach_tolerance);
         end
         default: begin
            goal   = (live_cfg.target_mode == MODE_LEAD_ZERO) ? 0 : int'(live_cfg.middle_point);
            spread = int'(live_cfg.reach_tolerance);
         end
      endcase
      steps  = $urandom_range(1, 6);
      settle = $urandom_range(1, 4);
      for (int a = 0; a < NUM_ACT; a++)
         start[a] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                : goal + int'($urandom_range(0, 12000)) - 6000;
      for (int k = 0; k < steps; k++) begin
         for (int a = 0; a < NUM_ACT; a++)
            item[a] = clip16(goal + (start[a] - goal) * (steps - k) / steps);
         queue_item(item);
      end
      for (int k = 0; k < settle; k++) begin
         for (int a = 0; a < NUM_ACT; a++) begin
            case ($urandom_range(0, 9))
               0: jit = spread;
               1: jit = -spread;
               2: jit = ($urandom_range(0, 3) == 0) ? spread + 1 : 0;
               default: jit = int'($urandom_range(0, 2 * spread)) - spread;
            endcase
            item[a] = clip16(goal + jit);
         end
         queue_item(item);
      end
   endtask

   // Scattered positions: full range, band edges, middle, tolerance and ceiling
   task automatic queue_noise_item();
      pos_set_type item;
      int mid, mar, top, base;
      mid = int'(live_cfg.middle_point);
      mar = int'(live_cfg.band_margin);
      top = int'(live_cfg.top_point);
      for (int a = 0; a < NUM_ACT; a++) begin
         case ($urandom_range(0, 6))
            0, 1: base = int'($urandom_range(0, 65535)) - 32768;
            2: base = mar;
            3: base = mid - mar;
            4: base = mid + mar;
            5: base = top - mar;
            default: begin
               case ($urandom_range(0, 2))
                  0: base = mid;
                  1: base = int'(live_cfg.reach_tolerance);
                  default: base = int'(live_cfg.command_ceiling);
               endcase
            end
         endcase
         item[a] = clip16(base + int'($urandom_range(0, 2)) - 1);
      end
      queue_item(item);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      int goal_count;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.pos_0   = '0;
      req_if.pos_1   = '0;
      req_if.pos_2   = '0;
      req_if.pos_3   = '0;
      req_if.pos_4   = '0;
      req_if.pos_5   = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.addr    = '0;
      csr_if.data    = '0;
      steady_run     = 1'b0;
      hold_off_armed = 1'b0;
      items_queued   = 0;
      request_count  = 0;
      response_count = 0;
      done_count     = 0;
      fault_count    = 0;
      settings_count = 1;
      cycle_count    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Seek middle at reset settings; first request already at the middle
      queue_lanes(5000, 5000, 5000, 5000, 5000, 5000);
      queue_lanes(-32768, 32767, 0, 1000, 1001, 3999);
      queue_lanes(4000, 4999, 5001, 6000, 6001, 8999);
      queue_lanes(9000, 9499, 9500, 10000, 16383, -1);
      queue_lanes(10070, 9930, 10070, 9930, 10000, 10070);
      queue_lanes(10071, 10000, 10000, 10000, 10000, 10000);
      queue_lanes(5035, 4965, 5035, 4965, 5000, 5035);
      queue_lanes(5036, 5000, 5000, 5000, 5000, 5000);
      queue_lanes(35, -35, 0, 35, -35, 0);
      wait_drained();

      // Mode change: held commands carry over into lead-to-zero
      set_register(REG_TARGET_MODE, MODE_LEAD_ZERO, 1);
      settings_count++;
      queue_lanes(0, 0, 0, 0, 0, 0);
      queue_lanes(35, 36, 34, -35, -36, 32767);
      queue_lanes(-32768, 0, 0, 0, 0, 0);
      queue_lanes(5000, 5000, 5000, 5000, 5000, 5000);
      wait_drained();

      // Inverted bands, zero tolerance, ceiling at zero
      set_register(REG_TARGET_MODE, MODE_SEEK_MIDDLE, 1);
      set_register(REG_FAST_STEP, 1023, 10);
      set_register(REG_SLOW_STEP, 1023, 10);
      set_register(REG_BAND_MARGIN, 8191, 13);
      set_register(REG_REACH_TOLERANCE, 0, 10);
      set_register(REG_MIDDLE_POINT, 16383, 14);
      set_register(REG_TOP_POINT, 16383, 14);
      set_register(REG_COMMAND_CEILING, 0, 14);
      set_register(REG_COMMAND_CEILING + 4'd8, 16'hFFFF, 16);
      settings_count++;
      queue_lanes(0, 100, 8192, 16383, 32767, -32768);
      queue_lanes(16383, 16383, 16383, 16383, 16383, 16383);
      queue_lanes(16382, 16383, 16383, 16383, 16383, 16383);
      wait_drained();

      // Zero steps and margin, middle and top at zero, widest tolerance
      set_register(REG_FAST_STEP, 0, 10);
      set_register(REG_SLOW_STEP, 0, 10);
      set_register(REG_BAND_MARGIN, 0, 13);
      set_register(REG_REACH_TOLERANCE, 1023, 10);
      set_register(REG_MIDDLE_POINT, 0, 14);
      set_register(REG_TOP_POINT, 0, 14);
      set_register(REG_COMMAND_CEILING, 16383, 14);
      settings_count++;
      queue_lanes(1, -1, 0, 1023, 1024, 32767);
      queue_lanes(-1023, -2046, 2046, 2047, -2047, 0);
      wait_drained();

      // Lead to zero with the largest slow step
      set_register(REG_TARGET_MODE, MODE_LEAD_ZERO, 1);
      set_register(REG_SLOW_STEP, 1023, 10);
      set_register(REG_REACH_TOLERANCE, 0, 10);
      settings_count++;
      queue_lanes(32767, -32768, 0, 1, -1, 0);
      queue_lanes(0, 0, 0, 0, 0, 0);
      wait_drained();

      // Random phases, alternating modes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_random_settings(phase[0] ? MODE_LEAD_ZERO : MODE_SEEK_MIDDLE);
         steady_run = (phase == 3);
         goal_count = items_queued + PHASE_ITEMS;
         while (items_queued < goal_count) begin
            if ($urandom_range(0, 9) < 7) queue_homing_run();
            else queue_noise_item();
         end
         // long receiver stall while the sender keeps offering
         if (phase == 5) hold_off_armed = 1'b1;
         wait_drained();
         steady_run = 1'b0;
      end

      if (expected_commands.size() != 0) begin
         fault_count++;
         $display("%0t ns: %0d expected responses never arrived", $time,
                  expected_commands.size());
      end
      $display("Ran %0d requests, %0d responses checked (%0d with target reached)",
               request_count, response_count, done_count);
      $display("over %0d register settings in both target modes", settings_count);
      if (fault_count == 0) begin
         $display("six_actuator_homing_stepper_test passed");
      end else begin
         $display("six_actuator_homing_stepper_test failed");
      end
      $finish;
   end

endmodule
